/* hdl/jpd_pkg.sv */
// Shared widths, reset values and helpers for the Jacobi preconditioner diagonal block.
package jpd_pkg;

    localparam int VERTEX_BITS_DEF = 20;
    localparam int LAMBDA_W        = 24;
    localparam int COUNT_W         = 16;
    localparam int NORM_W          = 24;
    localparam int CONF_W          = 16;
    localparam int DIAG_W          = 48;
    localparam int RECIP_W         = 32;
    localparam int MUL_A_W         = 32;
    localparam int MUL_P_W         = MUL_A_W + LAMBDA_W;
    localparam int NORM_TERM_W     = 40;
    localparam int SUM_W           = DIAG_W + 2;
    // quotient of 2^32 by the magnitude needs 33 bits, one step per bit
    localparam int DIV_STEPS       = 33;
    localparam int QUOT_W          = DIV_STEPS;
    localparam int STEP_W          = $clog2(DIV_STEPS);

    localparam logic [LAMBDA_W-1:0] LAMBDA_RESET = 24'd65536;

    localparam logic signed [DIAG_W-1:0] DIAG_MAX = {1'b0, {(DIAG_W-1){1'b1}}};
    localparam logic signed [DIAG_W-1:0] DIAG_MIN = {1'b1, {(DIAG_W-1){1'b0}}};

    // Clamp a widened sum to signed Q32.16
    function automatic logic signed [DIAG_W-1:0] sat_diag(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(DIAG_MAX);
        lo = SUM_W'(DIAG_MIN);
        if (v > hi)
            return DIAG_MAX;
        else if (v < lo)
            return DIAG_MIN;
        else
            return v[DIAG_W-1:0];
    endfunction

endpackage

/* hdl/jacobi_preconditioner_diagonal.sv */
// Jacobi preconditioner diagonal: per-vertex diagonal accumulate and reciprocal divide.
//
// Usage: pixel items enter on the s_axis channel, one confidence each. The item
// with first_of_vertex (s_axis_tuser) set carries the vertex terms; the item
// with s_axis_tlast set closes the vertex. An empty vertex is one item with both
// marks and confidence zero. The user must write the lambda register on the cfg
// channel while the block is idle, which it does not enforce; it resets to 1.0.
// An item that is neither first nor last is added in the idle state. A first
// item adds four passes through one shared 32x24 multiplier and a sum state. A
// last item then adds a check state, a restoring divide of 2^32 by the diagonal
// magnitude (one quotient bit per cycle) and an output state that loads the
// output register once it is free; the result turns valid in the same cycle that
// the input is ready again. A zero diagonal skips the divide.
// Results appear on m_axis with the vertex index, the saturated Q16.16 reciprocal
// and the zero-diagonal flag in m_axis_tuser.
// A stalled receiver holds the result in the output register; the block keeps
// taking items and only waits when a second result is ready to be loaded.
// Reset clears the running diagonal, the held vertex and all handshakes.
module jacobi_preconditioner_diagonal
    import jpd_pkg::*;
#(
    parameter int VERTEX_BITS = VERTEX_BITS_DEF,
    localparam int IN_FIELDS_W = VERTEX_BITS + COUNT_W + NORM_W + CONF_W,
    localparam int IN_DATA_W  = ((IN_FIELDS_W + 7) / 8) * 8,
    localparam int OUT_FIELDS_W = VERTEX_BITS + RECIP_W,
    localparam int OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write: lambda, unsigned Q8.16
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [LAMBDA_W-1:0]   cfg_data,
    // pixel items
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // low to high: vertex_index, splat_count, norm_weight, confidence, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // bit 0: first_of_vertex
    input  logic                  s_axis_tuser,
    // last_of_vertex
    input  logic                  s_axis_tlast,
    // preconditioner entries
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // low to high: out_vertex, reciprocal, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // bit 0: zero_diagonal
    output logic                  m_axis_tuser
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_NN,
        ST_MUL_HI,
        ST_MUL_LO,
        ST_MUL_CS,
        ST_SUM,
        ST_CHECK,
        ST_DIV,
        ST_OUT
    } state_t;

    // Input field slices
    logic [VERTEX_BITS-1:0] in_vertex;
    logic [COUNT_W-1:0]     in_count;
    logic [NORM_W-1:0]      in_norm;
    logic [CONF_W-1:0]      in_conf;

    assign in_vertex = s_axis_tdata[VERTEX_BITS-1:0];
    assign in_count  = s_axis_tdata[VERTEX_BITS+COUNT_W-1:VERTEX_BITS];
    assign in_norm   = s_axis_tdata[VERTEX_BITS+COUNT_W+NORM_W-1:VERTEX_BITS+COUNT_W];
    assign in_conf   = s_axis_tdata[IN_FIELDS_W-1:VERTEX_BITS+COUNT_W+NORM_W];

    state_t                    state_reg, state_next;
    logic [LAMBDA_W-1:0]       lambda_reg, lambda_next;
    logic signed [DIAG_W-1:0]  diag_reg, diag_next;
    logic [VERTEX_BITS-1:0]    held_vertex_reg, held_vertex_next;
    logic [COUNT_W-1:0]        count_reg, count_next;
    logic [NORM_W-1:0]         norm_reg, norm_next;
    logic [CONF_W-1:0]         conf_reg, conf_next;
    logic                      last_reg, last_next;
    logic [MUL_P_W-1:0]        prod_reg, prod_next;
    logic [MUL_P_W-1:0]        hi_reg, hi_next;
    logic [15:0]               plo_reg, plo_next;
    logic [NORM_TERM_W-1:0]    nterm_reg, nterm_next;
    logic [DIAG_W-1:0]         mag_reg, mag_next;
    logic                      neg_reg, neg_next;
    logic [DIAG_W-1:0]         rem_reg, rem_next;
    logic [QUOT_W-1:0]         quot_reg, quot_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic                      zero_reg, zero_next;
    logic                      out_valid_reg, out_valid_next;
    logic [VERTEX_BITS-1:0]    out_vertex_reg, out_vertex_next;
    logic [RECIP_W-1:0]        out_recip_reg, out_recip_next;
    logic                      out_zero_reg, out_zero_next;

    // Shared multiplier operands
    logic [MUL_A_W-1:0]   mul_a;
    logic [LAMBDA_W-1:0]  mul_b;
    logic [MUL_P_W-1:0]   mul_p;

    // Divider step
    logic                 div_bit;
    logic [DIAG_W-1:0]    rem_shift;
    logic                 rem_ge;

    // Output formatting
    logic [RECIP_W-1:0]   recip_val;
    logic                 in_accept;
    logic                 out_free;

    logic [NORM_TERM_W+16:0] nterm_sum;
    logic signed [SUM_W-1:0] first_sum;
    logic signed [SUM_W-1:0] next_sum;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;

    // Operand selection for the single multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = lambda_reg;
        case (state_reg)
            ST_MUL_NN:
            begin
                mul_a = MUL_A_W'(norm_reg);
                mul_b = norm_reg;
            end
            ST_MUL_HI: mul_a = prod_reg[47:16];
            ST_MUL_LO: mul_a = MUL_A_W'(plo_reg);
            ST_MUL_CS: mul_a = MUL_A_W'(count_reg);
            default:   mul_a = '0;
        endcase
        mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
    end

    // Sums of the diagonal terms
    assign nterm_sum = (NORM_TERM_W+17)'(hi_reg) + (NORM_TERM_W+17)'(prod_reg >> 16);
    assign first_sum = $signed(SUM_W'(prod_reg[39:0])) - $signed(SUM_W'(nterm_reg))
                     + $signed(SUM_W'(conf_reg));
    assign next_sum  = SUM_W'(diag_reg) + $signed(SUM_W'(in_conf));

    // Restoring divide step of 2^32 by the magnitude
    assign div_bit   = (step_reg == STEP_W'(DIV_STEPS - 1));
    assign rem_shift = {rem_reg[DIAG_W-2:0], div_bit};
    assign rem_ge    = (rem_shift >= mag_reg);

    // Saturated signed reciprocal from the quotient magnitude
    always_comb
    begin
        if (neg_reg)
        begin
            if (quot_reg > QUOT_W'(33'h080000000))
                recip_val = 32'h80000000;
            else
                recip_val = 32'(-quot_reg);
        end
        else
        begin
            if (quot_reg > QUOT_W'(33'h07FFFFFFF))
                recip_val = 32'h7FFFFFFF;
            else
                recip_val = quot_reg[RECIP_W-1:0];
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next       = state_reg;
        lambda_next      = lambda_reg;
        diag_next        = diag_reg;
        held_vertex_next = held_vertex_reg;
        count_next       = count_reg;
        norm_next        = norm_reg;
        conf_next        = conf_reg;
        last_next        = last_reg;
        prod_next        = prod_reg;
        hi_next          = hi_reg;
        plo_next         = plo_reg;
        nterm_next       = nterm_reg;
        mag_next         = mag_reg;
        neg_next         = neg_reg;
        rem_next         = rem_reg;
        quot_next        = quot_reg;
        step_next        = step_reg;
        zero_next        = zero_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_vertex_next  = out_vertex_reg;
        out_recip_next   = out_recip_reg;
        out_zero_next    = out_zero_reg;

        if (cfg_valid)
            lambda_next = cfg_data;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    count_next = in_count;
                    norm_next  = in_norm;
                    conf_next  = in_conf;
                    last_next  = s_axis_tlast;
                    if (s_axis_tuser)
                    begin
                        held_vertex_next = in_vertex;
                        state_next       = ST_MUL_NN;
                    end
                    else
                    begin
                        diag_next  = sat_diag(next_sum);
                        state_next = s_axis_tlast ? ST_CHECK : ST_IDLE;
                    end
                end
            end
            ST_MUL_NN:
            begin
                prod_next  = mul_p;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                plo_next   = prod_reg[15:0];
                prod_next  = mul_p;
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO:
            begin
                hi_next    = prod_reg;
                prod_next  = mul_p;
                state_next = ST_MUL_CS;
            end
            ST_MUL_CS:
            begin
                nterm_next = nterm_sum[NORM_TERM_W+16:17];
                prod_next  = mul_p;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                diag_next  = sat_diag(first_sum);
                state_next = last_reg ? ST_CHECK : ST_IDLE;
            end
            ST_CHECK:
            begin
                rem_next  = '0;
                quot_next = '0;
                step_next = STEP_W'(DIV_STEPS - 1);
                neg_next  = diag_reg[DIAG_W-1];
                mag_next  = diag_reg[DIAG_W-1] ? DIAG_W'(-diag_reg) : DIAG_W'(diag_reg);
                if (diag_reg == '0)
                begin
                    zero_next  = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    zero_next  = 1'b0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next  = rem_ge ? (rem_shift - mag_reg) : rem_shift;
                quot_next = {quot_reg[QUOT_W-2:0], rem_ge};
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_vertex_next = held_vertex_reg;
                    out_recip_next  = zero_reg ? '0 : recip_val;
                    out_zero_next   = zero_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            lambda_reg      <= LAMBDA_RESET;
            diag_reg        <= '0;
            held_vertex_reg <= '0;
            out_valid_reg   <= 1'b0;
            step_reg        <= '0;
            zero_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            lambda_reg      <= lambda_next;
            diag_reg        <= diag_next;
            held_vertex_reg <= held_vertex_next;
            out_valid_reg   <= out_valid_next;
            step_reg        <= step_next;
            zero_reg        <= zero_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        count_reg      <= count_next;
        norm_reg       <= norm_next;
        conf_reg       <= conf_next;
        last_reg       <= last_next;
        prod_reg       <= prod_next;
        hi_reg         <= hi_next;
        plo_reg        <= plo_next;
        nterm_reg      <= nterm_next;
        mag_reg        <= mag_next;
        neg_reg        <= neg_next;
        rem_reg        <= rem_next;
        quot_reg       <= quot_next;
        out_vertex_reg <= out_vertex_next;
        out_recip_reg  <= out_recip_next;
        out_zero_reg   <= out_zero_next;
    end

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_zero_reg;
    assign m_axis_tdata  = OUT_DATA_W'({out_recip_reg, out_vertex_reg});

    // A zero diagonal always reports a zero reciprocal
    a_zero_recip: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> out_recip_reg == '0)
        else $error("zero diagonal with nonzero reciprocal");

    // The divider never runs on a zero magnitude
    a_div_mag: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> mag_reg != '0)
        else $error("divide started on zero magnitude");

    // Remainder stays below the divisor throughout the divide
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> rem_reg < mag_reg)
        else $error("divide remainder out of range");

    // A middle pixel leaves the input ready again in the following cycle
    a_mid_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && !s_axis_tuser && !s_axis_tlast |=> s_axis_tready)
        else $error("middle pixel stalled the input");

endmodule
